### rtl/sgsh_pkg.sv
`timescale 1ns / 1ps
package sgsh_pkg;

  localparam int BUCKET_BITS       = 10;
  localparam int CELLS_PER_BUCKET  = 4;
  localparam int ENTITIES_PER_CELL = 16;
  localparam int MAX_SHOWN         = 16;

  localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
  localparam int NUM_CELLS   = NUM_BUCKETS * CELLS_PER_BUCKET;
  localparam int SLOT_W      = (CELLS_PER_BUCKET > 1) ? $clog2(CELLS_PER_BUCKET) : 1;
  localparam int BFILL_W     = $clog2(CELLS_PER_BUCKET + 1);
  localparam int EIDX_W      = (ENTITIES_PER_CELL > 1) ? $clog2(ENTITIES_PER_CELL) : 1;
  localparam int LFILL_W     = $clog2(ENTITIES_PER_CELL + 1);
  localparam int CELL_AW     = BUCKET_BITS + SLOT_W;
  localparam int ENT_AW      = CELL_AW + EIDX_W;
  localparam int CELLS_W     = $clog2(NUM_CELLS + 1);
  localparam int SHOWN_LIM   = (ENTITIES_PER_CELL < MAX_SHOWN) ? ENTITIES_PER_CELL : MAX_SHOWN;

  localparam logic [32:0] HASH_MUL = 33'h0_9e37_79b1;
  localparam logic [63:0] HASH_ADD = 64'h0000_0000_85eb_ca6b;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_QUERY  = 2'd3;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BUCKET_FULL = 2'd1;
  localparam logic [1:0] ST_LIST_FULL   = 2'd2;
  localparam logic [1:0] ST_NO_CELL     = 2'd3;

  localparam logic CFG_SHIFT = 1'b0;

  typedef struct packed {
    logic        valid;
    logic [1:0]  status;
    logic [15:0] entity;
    logic [15:0] order;
    logic [4:0]  len;
    logic        last;
  } res_t;

  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
  } box_t;

endpackage

### rtl/sgsh_ram.sv
`timescale 1ns / 1ps
module sgsh_ram #(
  parameter int AW = 10,
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/sgsh_hash.sv
`timescale 1ns / 1ps
module sgsh_hash (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] y_i,
  output logic               done_o,
  output logic [63:0]        hash_o
);
  import sgsh_pkg::*;

  logic [2:0]         v_q;
  logic [63:0]        p_q, a_q, t_q, h_q;
  logic signed [65:0] prod;

  // x sign-extended times the odd constant, modulo 2^64
  assign prod = $signed({x_i[31], x_i}) * $signed(HASH_MUL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p_q <= prod[63:0];
      a_q <= {{32{y_i[31]}}, y_i} + HASH_ADD;
    end
    t_q <= a_q + (p_q << 6);
    h_q <= p_q ^ (t_q + (p_q >> 2));
  end

  assign done_o = v_q[2];
  assign hash_o = h_q;

endmodule

### rtl/sgsh_ctrl.sv
`timescale 1ns / 1ps
module sgsh_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         mode_i,
  input  logic [15:0]        id_i,
  input  logic [15:0]        order_i,
  input  logic signed [31:0] x0_i,
  input  logic signed [31:0] y0_i,
  input  logic signed [31:0] x1_i,
  input  logic signed [31:0] y1_i,
  input  logic [4:0]         shift_i,
  output logic               busy_o,
  output sgsh_pkg::res_t     res_o,
  output sgsh_pkg::box_t     box_o
);
  import sgsh_pkg::*;

  localparam logic [4:0] S_INIT   = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_PREP   = 5'd2;
  localparam logic [4:0] S_HGO    = 5'd3;
  localparam logic [4:0] S_HWAIT  = 5'd4;
  localparam logic [4:0] S_BFILL  = 5'd5;
  localparam logic [4:0] S_KEY    = 5'd6;
  localparam logic [4:0] S_MISS   = 5'd7;
  localparam logic [4:0] S_FOUND  = 5'd8;
  localparam logic [4:0] S_ADD    = 5'd9;
  localparam logic [4:0] S_SHIFT  = 5'd10;
  localparam logic [4:0] S_PUT0   = 5'd11;
  localparam logic [4:0] S_NEXT   = 5'd12;
  localparam logic [4:0] S_QRD    = 5'd13;
  localparam logic [4:0] S_RB     = 5'd14;
  localparam logic [4:0] S_CLRC   = 5'd15;
  localparam logic [4:0] S_RL     = 5'd16;
  localparam logic [4:0] S_RE     = 5'd17;
  localparam logic [4:0] S_RFIN   = 5'd18;
  localparam logic [4:0] S_RNEXTC = 5'd19;
  localparam logic [4:0] S_RNEXTB = 5'd20;

  logic [4:0]             state_q, state_d;
  logic [1:0]             mode_q, mode_d;
  logic [15:0]            id_q, id_d, ord_q, ord_d;
  logic signed [31:0]     ax0_q, ax0_d, ay0_q, ay0_d, ax1_q, ax1_d, ay1_q, ay1_d;
  logic signed [31:0]     x_q, x_d, y_q, y_d, cy0_q, cy0_d, cx1_q, cx1_d, cy1_q, cy1_d;
  logic [63:0]            h_q, h_d;
  logic                   inbox_q, inbox_d, sh_q, sh_d;
  logic [BUCKET_BITS-1:0] b_q, b_d, b_inc;
  logic [BFILL_W-1:0]     j_q, j_d, nb_q, nb_d, j_inc;
  logic [CELL_AW-1:0]     c_q, c_d;
  logic [LFILL_W-1:0]     n_q, n_d, k_q, k_d, k_inc, k_dec, shown;
  logic [CELLS_W-1:0]     cells_q, cells_d;
  box_t                   box_q, box_d;
  res_t                   res_q, res_d;
  logic signed [31:0]     lox, loy, hix, hiy;

  logic                   hash_go, hash_done;
  logic [63:0]            hash_val;

  logic                   bf_we;
  logic [BUCKET_BITS-1:0] bf_waddr, bf_raddr;
  logic [BFILL_W-1:0]     bf_wdata, bf_rdata;
  logic                   key_we;
  logic [CELL_AW-1:0]     key_waddr, key_raddr;
  logic [63:0]            key_rdata;
  logic                   lf_we;
  logic [CELL_AW-1:0]     lf_waddr, lf_raddr;
  logic [LFILL_W-1:0]     lf_wdata, lf_rdata;
  logic                   ent_we;
  logic [ENT_AW-1:0]      ent_waddr, ent_raddr;
  logic [31:0]            ent_wdata, ent_rdata;
  logic [31:0]            new_word;

  function automatic logic [4:0] sat_len(input logic [LFILL_W-1:0] n);
    logic [4:0] r;
    r = (n > 31) ? 5'd31 : 5'(n);
    return r;
  endfunction

  sgsh_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_go),
    .x_i     (x_q),
    .y_i     (y_q),
    .done_o  (hash_done),
    .hash_o  (hash_val)
  );

  sgsh_ram #(.AW(BUCKET_BITS), .DW(BFILL_W)) u_bfill (
    .clk_i(clk_i), .we_i(bf_we), .waddr_i(bf_waddr), .wdata_i(bf_wdata),
    .raddr_i(bf_raddr), .rdata_o(bf_rdata)
  );
  sgsh_ram #(.AW(CELL_AW), .DW(64)) u_key (
    .clk_i(clk_i), .we_i(key_we), .waddr_i(key_waddr), .wdata_i(h_q),
    .raddr_i(key_raddr), .rdata_o(key_rdata)
  );
  sgsh_ram #(.AW(CELL_AW), .DW(LFILL_W)) u_lfill (
    .clk_i(clk_i), .we_i(lf_we), .waddr_i(lf_waddr), .wdata_i(lf_wdata),
    .raddr_i(lf_raddr), .rdata_o(lf_rdata)
  );
  sgsh_ram #(.AW(ENT_AW), .DW(32)) u_ent (
    .clk_i(clk_i), .we_i(ent_we), .waddr_i(ent_waddr), .wdata_i(ent_wdata),
    .raddr_i(ent_raddr), .rdata_o(ent_rdata)
  );

  assign b_inc    = b_q + 1'b1;
  assign j_inc    = j_q + 1'b1;
  assign k_inc    = k_q + 1'b1;
  assign k_dec    = k_q - 1'b1;
  assign shown    = (n_q > LFILL_W'(SHOWN_LIM)) ? LFILL_W'(SHOWN_LIM) : n_q;
  assign new_word = {id_q, ord_q};
  assign lox      = (ax0_q > ax1_q) ? ax1_q : ax0_q;
  assign hix      = (ax0_q > ax1_q) ? ax0_q : ax1_q;
  assign loy      = (ay0_q > ay1_q) ? ay1_q : ay0_q;
  assign hiy      = (ay0_q > ay1_q) ? ay0_q : ay1_q;

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    id_d    = id_q;
    ord_d   = ord_q;
    ax0_d   = ax0_q;
    ay0_d   = ay0_q;
    ax1_d   = ax1_q;
    ay1_d   = ay1_q;
    x_d     = x_q;
    y_d     = y_q;
    cy0_d   = cy0_q;
    cx1_d   = cx1_q;
    cy1_d   = cy1_q;
    h_d     = h_q;
    inbox_d = inbox_q;
    sh_d    = sh_q;
    b_d     = b_q;
    j_d     = j_q;
    nb_d    = nb_q;
    c_d     = c_q;
    n_d     = n_q;
    k_d     = k_q;
    cells_d = cells_q;
    box_d   = box_q;
    res_d   = '0;
    hash_go = 1'b0;

    bf_we     = 1'b0;
    bf_waddr  = b_q;
    bf_wdata  = '0;
    bf_raddr  = b_q;
    key_we    = 1'b0;
    key_waddr = c_q;
    key_raddr = c_q;
    lf_we     = 1'b0;
    lf_waddr  = c_q;
    lf_wdata  = '0;
    lf_raddr  = c_q;
    ent_we    = 1'b0;
    ent_waddr = {c_q, k_q[EIDX_W-1:0]};
    ent_wdata = new_word;
    ent_raddr = {c_q, k_q[EIDX_W-1:0]};

    case (state_q)
      S_INIT: begin
        // sweep the bucket fill memory to zero
        bf_we = 1'b1;
        b_d   = b_inc;
        if (b_q == BUCKET_BITS'(NUM_BUCKETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          mode_d  = mode_i;
          id_d    = id_i;
          ord_d   = order_i;
          ax0_d   = x0_i;
          ay0_d   = y0_i;
          ax1_d   = x1_i;
          ay1_d   = y1_i;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        if (mode_q == MODE_QUERY) begin
          x_d     = ax0_q >>> shift_i;
          y_d     = ay0_q >>> shift_i;
          state_d = S_HGO;
        end else if (mode_q == MODE_INSERT) begin
          x_d     = lox >>> shift_i;
          y_d     = loy >>> shift_i;
          cy0_d   = loy >>> shift_i;
          cx1_d   = hix >>> shift_i;
          cy1_d   = hiy >>> shift_i;
          state_d = S_HGO;
        end else begin
          b_d      = '0;
          bf_raddr = '0;
          state_d  = S_RB;
        end
      end
      S_HGO: begin
        hash_go = 1'b1;
        inbox_d = (cells_q != '0) && !(box_q.min_x > x_q) && !(box_q.max_x < x_q) &&
                  !(box_q.min_y > y_q) && !(box_q.max_y < y_q);
        state_d = S_HWAIT;
      end
      S_HWAIT: begin
        if (hash_done) begin
          h_d      = hash_val;
          b_d      = hash_val[BUCKET_BITS-1:0];
          bf_raddr = hash_val[BUCKET_BITS-1:0];
          state_d  = S_BFILL;
        end
      end
      S_BFILL: begin
        nb_d      = bf_rdata;
        j_d       = '0;
        key_raddr = {b_q, SLOT_W'(0)};
        if (!inbox_q || bf_rdata == '0) begin
          state_d = S_MISS;
        end else begin
          state_d = S_KEY;
        end
      end
      S_KEY: begin
        if (key_rdata == h_q) begin
          c_d      = {b_q, j_q[SLOT_W-1:0]};
          lf_raddr = {b_q, j_q[SLOT_W-1:0]};
          state_d  = S_FOUND;
        end else if (j_inc == nb_q) begin
          state_d = S_MISS;
        end else begin
          j_d       = j_inc;
          key_raddr = {b_q, j_inc[SLOT_W-1:0]};
        end
      end
      S_MISS: begin
        if (mode_q == MODE_QUERY) begin
          res_d.valid  = 1'b1;
          res_d.status = ST_NO_CELL;
          res_d.last   = 1'b1;
          state_d      = S_IDLE;
        end else if (nb_q >= BFILL_W'(CELLS_PER_BUCKET)) begin
          res_d.valid  = 1'b1;
          res_d.status = ST_BUCKET_FULL;
          res_d.last   = 1'b1;
          state_d      = S_IDLE;
        end else begin
          // append the new cell to its bucket; equal keys stay in creation order
          c_d       = {b_q, nb_q[SLOT_W-1:0]};
          key_we    = 1'b1;
          key_waddr = {b_q, nb_q[SLOT_W-1:0]};
          lf_we     = 1'b1;
          lf_waddr  = {b_q, nb_q[SLOT_W-1:0]};
          bf_we     = 1'b1;
          bf_wdata  = nb_q + 1'b1;
          cells_d   = cells_q + 1'b1;
          if (box_q.min_x > x_q) box_d.min_x = x_q;
          if (box_q.min_y > y_q) box_d.min_y = y_q;
          if (box_q.max_x < x_q) box_d.max_x = x_q;
          if (box_q.max_y < y_q) box_d.max_y = y_q;
          n_d     = '0;
          state_d = S_ADD;
        end
      end
      S_FOUND: begin
        n_d = lf_rdata;
        k_d = '0;
        if (mode_q == MODE_QUERY) begin
          if (lf_rdata == '0) begin
            res_d.valid = 1'b1;
            res_d.last  = 1'b1;
            state_d     = S_IDLE;
          end else begin
            ent_raddr = {c_q, EIDX_W'(0)};
            state_d   = S_QRD;
          end
        end else begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        if (n_q >= LFILL_W'(ENTITIES_PER_CELL)) begin
          res_d.valid  = 1'b1;
          res_d.status = ST_LIST_FULL;
          res_d.last   = 1'b1;
          state_d      = S_IDLE;
        end else if (n_q == '0) begin
          ent_we    = 1'b1;
          ent_waddr = {c_q, EIDX_W'(0)};
          state_d   = S_NEXT;
        end else begin
          k_d       = n_q - 1'b1;
          ent_raddr = {c_q, EIDX_W'(n_q - 1'b1)};
          state_d   = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // walk down from the tail, moving entries of lower or equal order up
        if (ent_rdata[15:0] <= ord_q) begin
          ent_we    = 1'b1;
          ent_waddr = {c_q, k_inc[EIDX_W-1:0]};
          ent_wdata = ent_rdata;
          if (k_q == '0) begin
            state_d = S_PUT0;
          end else begin
            k_d       = k_dec;
            ent_raddr = {c_q, k_dec[EIDX_W-1:0]};
          end
        end else begin
          ent_we    = 1'b1;
          ent_waddr = {c_q, k_inc[EIDX_W-1:0]};
          state_d   = S_NEXT;
        end
      end
      S_PUT0: begin
        ent_we    = 1'b1;
        ent_waddr = {c_q, EIDX_W'(0)};
        state_d   = S_NEXT;
      end
      S_NEXT: begin
        lf_we    = 1'b1;
        lf_wdata = n_q + 1'b1;
        if (y_q == cy1_q) begin
          if (x_q == cx1_q) begin
            res_d.valid = 1'b1;
            res_d.last  = 1'b1;
            state_d     = S_IDLE;
          end else begin
            x_d     = x_q + 32'sd1;
            y_d     = cy0_q;
            state_d = S_HGO;
          end
        end else begin
          y_d     = y_q + 32'sd1;
          state_d = S_HGO;
        end
      end
      S_QRD: begin
        res_d.valid  = 1'b1;
        res_d.entity = ent_rdata[31:16];
        res_d.order  = ent_rdata[15:0];
        res_d.len    = sat_len(n_q);
        res_d.last   = (k_inc == shown);
        if (k_inc == shown) begin
          state_d = S_IDLE;
        end else begin
          k_d       = k_inc;
          ent_raddr = {c_q, k_inc[EIDX_W-1:0]};
        end
      end
      S_RB: begin
        nb_d = bf_rdata;
        j_d  = '0;
        c_d  = {b_q, SLOT_W'(0)};
        if (bf_rdata == '0) begin
          state_d = S_RNEXTB;
        end else if (mode_q == MODE_CLEAR) begin
          state_d = S_CLRC;
        end else begin
          lf_raddr = {b_q, SLOT_W'(0)};
          state_d  = S_RL;
        end
      end
      S_CLRC: begin
        lf_we    = 1'b1;
        lf_waddr = {b_q, j_q[SLOT_W-1:0]};
        if (j_inc == nb_q) begin
          state_d = S_RNEXTB;
        end else begin
          j_d = j_inc;
        end
      end
      S_RL: begin
        n_d  = lf_rdata;
        k_d  = '0;
        sh_d = 1'b0;
        if (lf_rdata == '0) begin
          state_d = S_RNEXTC;
        end else begin
          ent_raddr = {c_q, EIDX_W'(0)};
          state_d   = S_RE;
        end
      end
      S_RE: begin
        // after the first match, pull each later entry down by one
        if (sh_q) begin
          ent_we    = 1'b1;
          ent_waddr = {c_q, k_dec[EIDX_W-1:0]};
          ent_wdata = ent_rdata;
        end else if (ent_rdata[31:16] == id_q) begin
          sh_d = 1'b1;
        end
        if (k_inc == n_q) begin
          state_d = S_RFIN;
        end else begin
          k_d       = k_inc;
          ent_raddr = {c_q, k_inc[EIDX_W-1:0]};
        end
      end
      S_RFIN: begin
        if (sh_q) begin
          lf_we    = 1'b1;
          lf_wdata = n_q - 1'b1;
        end
        state_d = S_RNEXTC;
      end
      S_RNEXTC: begin
        if (j_inc == nb_q) begin
          state_d = S_RNEXTB;
        end else begin
          j_d      = j_inc;
          c_d      = {b_q, j_inc[SLOT_W-1:0]};
          lf_raddr = {b_q, j_inc[SLOT_W-1:0]};
          state_d  = S_RL;
        end
      end
      S_RNEXTB: begin
        if (b_q == BUCKET_BITS'(NUM_BUCKETS - 1)) begin
          res_d.valid = 1'b1;
          res_d.last  = 1'b1;
          state_d     = S_IDLE;
        end else begin
          b_d      = b_inc;
          bf_raddr = b_inc;
          state_d  = S_RB;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      b_q     <= '0;
      cells_q <= '0;
      box_q   <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      b_q     <= b_d;
      cells_q <= cells_d;
      box_q   <= box_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    id_q    <= id_d;
    ord_q   <= ord_d;
    ax0_q   <= ax0_d;
    ay0_q   <= ay0_d;
    ax1_q   <= ax1_d;
    ay1_q   <= ay1_d;
    x_q     <= x_d;
    y_q     <= y_d;
    cy0_q   <= cy0_d;
    cx1_q   <= cx1_d;
    cy1_q   <= cy1_d;
    h_q     <= h_d;
    inbox_q <= inbox_d;
    sh_q    <= sh_d;
    j_q     <= j_d;
    nb_q    <= nb_d;
    c_q     <= c_d;
    n_q     <= n_d;
    k_q     <= k_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign res_o  = res_q;
  assign box_o  = box_q;

endmodule

### rtl/sparse_grid_spatial_hash.sv
`timescale 1ns / 1ps
// Sparse spatial hash over grid cells, kept in on-chip memories.
// Command channel: present mode and payload with start high; the word is
// taken at the edge where start is high and busy is low. Insert (mode 0) adds
// the entity to every cell its box covers, creating cells as needed; remove
// (mode 1) drops the entity from every cell; clear (mode 2) empties all
// lists; query (mode 3) streams the entities of one cell.
// Result channel: result_valid_o marks each result word for one cycle and
// the receiver takes it there, it cannot hold results off. Insert, remove
// and clear give one word; a query gives one word per listed entity
// (up to 16), back to back, last_result_o on the final one; a missing or
// empty cell gives a single word. Insert visits each cell in turn: the hash
// unit, then a compare of each key in the bucket, then the entries moved
// down the list. Remove and clear walk every bucket: clear resets the list
// fill of each cell, remove scans the entries of each cell. busy drops as
// the last word shows. Config: cell_shift sits at APB byte address 0.
// The user writes it only while idle; the block itself does not enforce this.
// Reset: a clearing pass zeroes all 1024 entries of the bucket fill memory;
// busy stays high until it ends. Bounding box and cell count reset to zero.
module sparse_grid_spatial_hash (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode_i,
  input  logic [15:0]        entity_id_i,
  input  logic [15:0]        entity_order_i,
  input  logic signed [31:0] corner_x0_i,
  input  logic signed [31:0] corner_y0_i,
  input  logic signed [31:0] corner_x1_i,
  input  logic signed [31:0] corner_y1_i,
  output logic               result_valid_o,
  output logic [1:0]         status_o,
  output logic [15:0]        found_entity_o,
  output logic [15:0]        found_order_o,
  output logic [4:0]         list_length_o,
  output logic               last_result_o,
  output logic signed [31:0] box_min_x_o,
  output logic signed [31:0] box_min_y_o,
  output logic signed [31:0] box_max_x_o,
  output logic signed [31:0] box_max_y_o
);
  import sgsh_pkg::*;

  logic [4:0] shift_q;
  res_t       res;
  box_t       box;

  // register write lands on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
    end else if (psel && penable && pwrite && paddr[2] == CFG_SHIFT) begin
      shift_q <= pwdata[4:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_SHIFT) ? {27'd0, shift_q} : 32'd0;

  sgsh_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .mode_i  (mode_i),
    .id_i    (entity_id_i),
    .order_i (entity_order_i),
    .x0_i    (corner_x0_i),
    .y0_i    (corner_y0_i),
    .x1_i    (corner_x1_i),
    .y1_i    (corner_y1_i),
    .shift_i (shift_q),
    .busy_o  (busy),
    .res_o   (res),
    .box_o   (box)
  );

  assign result_valid_o = res.valid;
  assign status_o       = res.status;
  assign found_entity_o = res.entity;
  assign found_order_o  = res.order;
  assign list_length_o  = res.len;
  assign last_result_o  = res.last;
  assign box_min_x_o    = box.min_x;
  assign box_min_y_o    = box.min_y;
  assign box_max_x_o    = box.max_x;
  assign box_max_y_o    = box.max_y;

endmodule

### rtl/sgsh_check.sv
`timescale 1ns / 1ps
module sgsh_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input logic [1:0]  status_o,
  input logic [15:0] found_entity_o,
  input logic [4:0]  list_length_o,
  input logic        last_result_o
);
  import sgsh_pkg::*;

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("command word taken but block not busy");

  a_stream_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_result_o |=> result_valid_o)
    else $error("gap in query result stream");

  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o != ST_OK |-> last_result_o)
    else $error("error status on a non-final word");

  a_no_cell_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == ST_NO_CELL |-> list_length_o == 5'd0 &&
    found_entity_o == 16'd0)
    else $error("missing cell reported with entries");

endmodule

bind sparse_grid_spatial_hash sgsh_check u_sgsh_check (.*);
